[hw/rtl/kabf_pkg.sv]
package kabf_pkg;

  // operand widths of the shared datapath
  localparam int unsigned AddW = 34;
  localparam int unsigned MulW = 33;
  localparam int unsigned AccW = 66;
  localparam int unsigned DenW = 33;

  // configuration port
  localparam int unsigned CfgW = 31;
  localparam int unsigned IdxW = 2;

  localparam logic [CfgW-1:0] AngleNoiseRst = 31'd268435;
  localparam logic [CfgW-1:0] BiasNoiseRst  = 31'd805306;
  localparam logic [CfgW-1:0] MeasNoiseRst  = 31'd8053064;

  typedef enum logic [IdxW-1:0] {
    CFG_ANGLE_NOISE = 2'd0,
    CFG_BIAS_NOISE  = 2'd1,
    CFG_MEAS_NOISE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ALU_ADD,
    ALU_MUL
  } alu_op_e;

  typedef enum logic {
    SHIFT_Q16,
    SHIFT_Q28
  } mul_shift_e;

  // add form: a + b - c - d, mul form: round(mul_a * mul_b >> shift)
  typedef struct packed {
    alu_op_e               op;
    mul_shift_e            shift;
    logic signed [AddW-1:0] add_a;
    logic signed [AddW-1:0] add_b;
    logic signed [AddW-1:0] sub_c;
    logic signed [AddW-1:0] sub_d;
    logic signed [MulW-1:0] mul_a;
    logic signed [MulW-1:0] mul_b;
  } alu_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    STEP_RATE,
    STEP_DT_RATE,
    STEP_ANGLE_PRED,
    STEP_DT_P11,
    STEP_U,
    STEP_DT_U,
    STEP_P00_PRED,
    STEP_P01_PRED,
    STEP_P10_PRED,
    STEP_QB_DT,
    STEP_P11_PRED,
    STEP_INNOV,
    STEP_K0_Y,
    STEP_ANGLE_CORR,
    STEP_K1_Y,
    STEP_BIAS_CORR,
    STEP_K1_P00,
    STEP_P10_CORR,
    STEP_K1_P01,
    STEP_P11_CORR,
    STEP_K0_P00,
    STEP_P00_CORR,
    STEP_K0_P01,
    STEP_P01_CORR
  } step_e;

  typedef enum logic [3:0] {
    DST_RATE,
    DST_ANGLE,
    DST_BIAS,
    DST_T,
    DST_M,
    DST_P00,
    DST_P01,
    DST_P10,
    DST_P11
  } dest_e;

endpackage

[hw/rtl/kalman_angle_bias_filter_core.sv]
// one item at a time: a new input is taken only in idle, after the previous result has
// been loaded into the output register, which waits while an earlier result is unaccepted.
// 24 passes through the shared add/multiply unit, each issued and then written back;
// the two gain divisions run only when p00 + r is positive, one quotient bit per cycle
// reset: estimates and covariance clear, noise registers load their defaults
module kalman_angle_bias_filter_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kabf_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [kabf_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // meas_angle [31:0], gyro_rate [63:32], time_step [79:64]
  input  logic [79:0]                 s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // est_angle [31:0], est_bias [63:32], unbiased_rate [95:64]
  output logic [95:0]                 m_axis_tdata
);
  import kabf_pkg::*;

  localparam int unsigned SatW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic [CfgW-1:0] NoiseMax = CfgW'((64'd1 << (SatW - 1)) - 64'd1);

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   div_sel_q, div_sel_d;

  logic [CfgW-1:0] angle_noise_q, bias_noise_q, meas_noise_q;
  logic [CfgW-1:0] qa_sat, qb_sat;

  logic signed [31:0] meas_q, gyro_q;
  logic [15:0]        dt_q;

  logic signed [SatW-1:0] angle_q, bias_q, rate_q;
  logic signed [SatW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [SatW-1:0] t_q, m_q, k0_q, k1_q;

  logic signed [31:0] out_angle_q, out_bias_q, out_rate_q;
  logic               out_valid_q;

  logic signed [AddW-1:0] innov_var;
  logic                   var_pos;

  alu_req_t               alu_req;
  dest_e                  dest;
  logic                   alu_start, alu_done;
  logic signed [SatW-1:0] alu_res;
  logic                   div_start, div_done;
  logic signed [SatW-1:0] div_quo;

  logic wb_en, k_clear, k_load, in_load, out_load;

  assign qa_sat    = (angle_noise_q > NoiseMax) ? NoiseMax : angle_noise_q;
  assign qb_sat    = (bias_noise_q > NoiseMax) ? NoiseMax : bias_noise_q;
  assign innov_var = AddW'(p00_q) + $signed(AddW'(meas_noise_q));
  assign var_pos   = innov_var > 0;

  kabf_alu #(
    .SAT_W(SatW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(alu_start),
    .req_i  (alu_req),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  kabf_div #(
    .SAT_W(SatW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_sel_q ? p10_q : p00_q),
    .den_i  (innov_var[DenW-1:0]),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // operation sequence of one update
  always_comb begin
    alu_req       = '0;
    alu_req.op    = ALU_ADD;
    alu_req.shift = SHIFT_Q16;
    dest          = DST_M;
    case (step_q)
      STEP_RATE: begin
        alu_req.add_a = AddW'(gyro_q);
        alu_req.sub_c = AddW'(bias_q);
        dest          = DST_RATE;
      end
      STEP_DT_RATE: begin
        alu_req.op    = ALU_MUL;
        alu_req.mul_a = MulW'(dt_q);
        alu_req.mul_b = MulW'(rate_q);
      end
      STEP_ANGLE_PRED: begin
        alu_req.add_a = AddW'(angle_q);
        alu_req.add_b = AddW'(m_q);
        dest          = DST_ANGLE;
      end
      STEP_DT_P11: begin
        alu_req.op    = ALU_MUL;
        alu_req.mul_a = MulW'(dt_q);
        alu_req.mul_b = MulW'(p11_q);
        dest          = DST_T;
      end
      STEP_U: begin
        alu_req.add_a = AddW'(t_q);
        alu_req.add_b = AddW'(qa_sat);
        alu_req.sub_c = AddW'(p01_q);
        alu_req.sub_d = AddW'(p10_q);
      end
      STEP_DT_U: begin
        alu_req.op    = ALU_MUL;
        alu_req.mul_a = MulW'(dt_q);
        alu_req.mul_b = MulW'(m_q);
      end
      STEP_P00_PRED: begin
        alu_req.add_a = AddW'(p00_q);
        alu_req.add_b = AddW'(m_q);
        dest          = DST_P00;
      end
      STEP_P01_PRED: begin
        alu_req.add_a = AddW'(p01_q);
        alu_req.sub_c = AddW'(t_q);
        dest          = DST_P01;
      end
      STEP_P10_PRED: begin
        alu_req.add_a = AddW'(p10_q);
        alu_req.sub_c = AddW'(t_q);
        dest          = DST_P10;
      end
      STEP_QB_DT: begin
        alu_req.op    = ALU_MUL;
        alu_req.mul_a = MulW'(qb_sat);
        alu_req.mul_b = MulW'(dt_q);
      end
      STEP_P11_PRED: begin
        alu_req.add_a = AddW'(p11_q);
        alu_req.add_b = AddW'(m_q);
        dest          = DST_P11;
      end
      STEP_INNOV: begin
        alu_req.add_a = AddW'(meas_q);
        alu_req.sub_c = AddW'(angle_q);
        dest          = DST_T;
      end
      STEP_K0_Y: begin
        alu_req.op    = ALU_MUL;
        alu_req.shift = SHIFT_Q28;
        alu_req.mul_a = MulW'(k0_q);
        alu_req.mul_b = MulW'(t_q);
      end
      STEP_ANGLE_CORR: begin
        alu_req.add_a = AddW'(angle_q);
        alu_req.add_b = AddW'(m_q);
        dest          = DST_ANGLE;
      end
      STEP_K1_Y: begin
        alu_req.op    = ALU_MUL;
        alu_req.shift = SHIFT_Q28;
        alu_req.mul_a = MulW'(k1_q);
        alu_req.mul_b = MulW'(t_q);
      end
      STEP_BIAS_CORR: begin
        alu_req.add_a = AddW'(bias_q);
        alu_req.add_b = AddW'(m_q);
        dest          = DST_BIAS;
      end
      // p10 and p11 go first so p00 and p01 are still the predicted values
      STEP_K1_P00: begin
        alu_req.op    = ALU_MUL;
        alu_req.shift = SHIFT_Q28;
        alu_req.mul_a = MulW'(k1_q);
        alu_req.mul_b = MulW'(p00_q);
      end
      STEP_P10_CORR: begin
        alu_req.add_a = AddW'(p10_q);
        alu_req.sub_c = AddW'(m_q);
        dest          = DST_P10;
      end
      STEP_K1_P01: begin
        alu_req.op    = ALU_MUL;
        alu_req.shift = SHIFT_Q28;
        alu_req.mul_a = MulW'(k1_q);
        alu_req.mul_b = MulW'(p01_q);
      end
      STEP_P11_CORR: begin
        alu_req.add_a = AddW'(p11_q);
        alu_req.sub_c = AddW'(m_q);
        dest          = DST_P11;
      end
      STEP_K0_P00: begin
        alu_req.op    = ALU_MUL;
        alu_req.shift = SHIFT_Q28;
        alu_req.mul_a = MulW'(k0_q);
        alu_req.mul_b = MulW'(p00_q);
      end
      STEP_P00_CORR: begin
        alu_req.add_a = AddW'(p00_q);
        alu_req.sub_c = AddW'(m_q);
        dest          = DST_P00;
      end
      STEP_K0_P01: begin
        alu_req.op    = ALU_MUL;
        alu_req.shift = SHIFT_Q28;
        alu_req.mul_a = MulW'(k0_q);
        alu_req.mul_b = MulW'(p01_q);
      end
      STEP_P01_CORR: begin
        alu_req.add_a = AddW'(p01_q);
        alu_req.sub_c = AddW'(m_q);
        dest          = DST_P01;
      end
      default: begin
        dest = DST_M;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_RATE;
      div_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      div_sel_q <= div_sel_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    div_sel_d     = div_sel_q;
    s_axis_tready = 1'b0;
    alu_start     = 1'b0;
    div_start     = 1'b0;
    wb_en         = 1'b0;
    k_clear       = 1'b0;
    k_load        = 1'b0;
    in_load       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          in_load = 1'b1;
          step_d  = STEP_RATE;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        alu_start = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        if (alu_done) begin
          wb_en = 1'b1;
          if (step_q == STEP_P11_PRED) begin
            if (var_pos) begin
              div_sel_d = 1'b0;
              state_d   = ST_DIV_START;
            end else begin
              // no usable innovation variance: zero gains, correction is a no-op
              k_clear = 1'b1;
              step_d  = STEP_INNOV;
              state_d = ST_ISSUE;
            end
          end else if (step_q == STEP_P01_CORR) begin
            state_d = ST_OUT;
          end else begin
            step_d  = step_e'(step_q + 5'd1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          k_load = 1'b1;
          if (!div_sel_q) begin
            div_sel_d = 1'b1;
            state_d   = ST_DIV_START;
          end else begin
            step_d  = STEP_INNOV;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_noise_q <= AngleNoiseRst;
      bias_noise_q  <= BiasNoiseRst;
      meas_noise_q  <= MeasNoiseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE_NOISE: angle_noise_q <= cfg_data_i;
        CFG_BIAS_NOISE:  bias_noise_q  <= cfg_data_i;
        CFG_MEAS_NOISE:  meas_noise_q  <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      p00_q   <= '0;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= '0;
    end else if (wb_en) begin
      case (dest)
        DST_ANGLE: angle_q <= alu_res;
        DST_BIAS:  bias_q  <= alu_res;
        DST_P00:   p00_q   <= alu_res;
        DST_P01:   p01_q   <= alu_res;
        DST_P10:   p10_q   <= alu_res;
        DST_P11:   p11_q   <= alu_res;
        default:   ;
      endcase
    end
  end

  // per-item operands and scratch values
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      meas_q <= s_axis_tdata[31:0];
      gyro_q <= s_axis_tdata[63:32];
      dt_q   <= s_axis_tdata[79:64];
    end
    if (wb_en) begin
      case (dest)
        DST_RATE: rate_q <= alu_res;
        DST_T:    t_q    <= alu_res;
        DST_M:    m_q    <= alu_res;
        default:  ;
      endcase
    end
    if (k_clear) begin
      k0_q <= '0;
      k1_q <= '0;
    end else if (k_load) begin
      if (div_sel_q) begin
        k1_q <= div_quo;
      end else begin
        k0_q <= div_quo;
      end
    end
    if (out_load) begin
      out_angle_q <= 32'(angle_q);
      out_bias_q  <= 32'(bias_q);
      out_rate_q  <= 32'(rate_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rate_q, out_bias_q, out_angle_q};

endmodule

[hw/rtl/kabf_alu.sv]
module kabf_alu #(
  parameter int unsigned SAT_W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  kabf_pkg::alu_req_t  req_i,
  output logic                done_o,
  output logic signed [SAT_W-1:0] res_o
);
  import kabf_pkg::*;

  localparam logic signed [AccW-1:0] SatMax = (66'sd1 <<< (SAT_W - 1)) - 66'sd1;
  localparam logic signed [AccW-1:0] SatMin = -SatMax - 66'sd1;
  localparam logic signed [AccW-1:0] Half16 = 66'sd1 <<< 15;
  localparam logic signed [AccW-1:0] Half28 = 66'sd1 <<< 27;

  logic signed [AccW-1:0] product;
  logic signed [AccW-1:0] sum;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] rnd;
  alu_op_e                op_q;
  mul_shift_e             shift_q;
  logic                   valid_q;

  assign product = $signed(req_i.mul_a) * $signed(req_i.mul_b);
  assign sum = AccW'($signed(req_i.add_a)) + AccW'($signed(req_i.add_b))
             - AccW'($signed(req_i.sub_c)) - AccW'($signed(req_i.sub_d));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= (req_i.op == ALU_MUL) ? product : sum;
      op_q    <= req_i.op;
      shift_q <= req_i.shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  // multiplies round to nearest with ties up; every result is then clamped
  always_comb begin
    rnd = acc_q;
    if (op_q == ALU_MUL) begin
      case (shift_q)
        SHIFT_Q16: rnd = (acc_q + Half16) >>> 16;
        SHIFT_Q28: rnd = (acc_q + Half28) >>> 28;
        default:   rnd = acc_q;
      endcase
    end
    if (rnd > SatMax) begin
      res_o = SatMax[SAT_W-1:0];
    end else if (rnd < SatMin) begin
      res_o = SatMin[SAT_W-1:0];
    end else begin
      res_o = rnd[SAT_W-1:0];
    end
  end

  assign done_o = valid_q;

endmodule

[hw/rtl/kabf_div.sv]
module kabf_div #(
  parameter int unsigned SAT_W = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SAT_W-1:0]    num_i,
  input  logic [kabf_pkg::DenW-1:0]  den_i,
  output logic                       done_o,
  output logic signed [SAT_W-1:0]    quo_o
);
  import kabf_pkg::*;

  localparam int unsigned QuoW  = 32;
  localparam int unsigned FracW = 28;
  localparam int unsigned NumW  = QuoW + FracW;
  localparam int unsigned CntW  = $clog2(QuoW);
  localparam logic [QuoW-1:0] QuoMax = 32'h8000_0000;
  localparam logic signed [AddW-1:0] SatMax = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
  localparam logic signed [AddW-1:0] SatMin = -SatMax - 34'sd1;

  logic                   neg;
  logic signed [QuoW:0]   num_ext;
  logic [QuoW:0]          mag;
  logic [NumW-1:0]        dividend;
  logic                   ovf;

  logic                   busy_q;
  logic                   done_q;
  logic [CntW-1:0]        cnt_q;
  logic [DenW-1:0]        den_q;
  logic [DenW-1:0]        rem_q;
  logic [QuoW-1:0]        low_q;
  logic [QuoW-1:0]        quo_q;
  logic                   neg_q;
  logic                   ovf_q;

  logic [DenW:0]          trial;
  logic                   fits;
  logic [DenW:0]          trial_sub;
  logic [QuoW-1:0]        quo_mag;
  logic signed [AddW-1:0] quo_signed;

  // magnitude of num, scaled by 2^28, plus half the divisor for rounding
  assign neg      = num_i < 0;
  assign num_ext  = (QuoW + 1)'(num_i);
  assign mag      = neg ? (QuoW + 1)'(-num_ext) : (QuoW + 1)'(num_ext);
  assign dividend = {mag[QuoW-1:0], {FracW{1'b0}}} + NumW'(den_i >> 1);
  assign ovf      = DenW'(dividend[NumW-1:QuoW]) >= den_i;

  assign trial     = {rem_q, low_q[QuoW-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DenW'(dividend[NumW-1:QuoW]);
      low_q <= dividend[QuoW-1:0];
      neg_q <= neg;
      ovf_q <= ovf;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[DenW-1:0] : trial[DenW-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuoW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // gain magnitude tops out at 8.0 (2^31 at 28 fraction bits) before the sign goes back on
  always_comb begin
    quo_mag    = (ovf_q || quo_q > QuoMax) ? QuoMax : quo_q;
    quo_signed = neg_q ? -$signed({2'b00, quo_mag}) : $signed({2'b00, quo_mag});
    if (quo_signed > SatMax) begin
      quo_o = SatMax[SAT_W-1:0];
    end else if (quo_signed < SatMin) begin
      quo_o = SatMin[SAT_W-1:0];
    end else begin
      quo_o = quo_signed[SAT_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

[verif/kalman_angle_bias_filter_core_tb.sv]
`timescale 1ns / 1ps

module kalman_angle_bias_filter_core_tb;
  import kabf_pkg::*;

  localparam logic [IdxW-1:0] CfgIdxUnused = 2'd3;
  localparam logic [CfgW-1:0] CfgMax = 31'h7fff_ffff;
  localparam longint Sat32Max = 64'sd2147483647;
  localparam longint Sat32Min = -64'sd2147483648;
  localparam int DrainCycles = 130;

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] bias;
    logic signed [31:0] angle;
  } filt_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [IdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // meas_angle [31:0], gyro_rate [63:32], time_step [79:64]
  logic [79:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // est_angle [31:0], est_bias [63:32], unbiased_rate [95:64]
  logic [95:0] m_axis_tdata;

  kalman_angle_bias_filter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // filter model state
  longint kf_angle, kf_bias;
  longint kf_p00, kf_p01, kf_p10, kf_p11;
  longint kf_qa, kf_qb, kf_r;

  filt_out_t expected_q[$];
  int send_idle_pct, recv_idle_pct;
  int hold_request, hold_left;
  int errors, samples_sent, results_checked, noise_sets, zero_gain_steps;

  // motion model for well-formed sample streams
  longint true_angle, true_rate, true_bias;

  function automatic longint sat32(longint v);
    if (v > Sat32Max) return Sat32Max;
    if (v < Sat32Min) return Sat32Min;
    return v;
  endfunction

  // product rounded to nearest, ties up
  function automatic longint mul_rnd(longint a, longint b, int sh);
    longint p;
    p = a * b + (64'sd1 <<< (sh - 1));
    return sat32(p >>> sh);
  endfunction

  // (num << 28) / den, ties away from zero, den positive
  function automatic longint div_gain(longint num, longint den);
    logic neg;
    longint unsigned mag, q;
    longint r;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << 28) + longint'(den) / 2) / longint'(den);
    r = (q > 64'd2147483648) ? 64'sd2147483648 : longint'(q);
    return sat32(neg ? -r : r);
  endfunction

  function automatic filt_out_t kf_update(longint meas, longint gyro, longint dt);
    longint rate, t, u, s, k0, k1, y, c00, c01;
    filt_out_t res;
    k0 = 0;
    k1 = 0;
    rate = sat32(gyro - kf_bias);
    kf_angle = sat32(kf_angle + mul_rnd(dt, rate, 16));
    t = mul_rnd(dt, kf_p11, 16);
    u = sat32(t - kf_p01 - kf_p10 + sat32(kf_qa));
    kf_p00 = sat32(kf_p00 + mul_rnd(dt, u, 16));
    kf_p01 = sat32(kf_p01 - t);
    kf_p10 = sat32(kf_p10 - t);
    kf_p11 = sat32(kf_p11 + mul_rnd(sat32(kf_qb), dt, 16));
    s = kf_p00 + kf_r;
    if (s > 0) begin
      k0 = div_gain(kf_p00, s);
      k1 = div_gain(kf_p10, s);
    end else begin
      zero_gain_steps++;
    end
    y = sat32(meas - kf_angle);
    kf_angle = sat32(kf_angle + mul_rnd(k0, y, 28));
    kf_bias = sat32(kf_bias + mul_rnd(k1, y, 28));
    c00 = kf_p00;
    c01 = kf_p01;
    kf_p00 = sat32(kf_p00 - mul_rnd(k0, c00, 28));
    kf_p01 = sat32(kf_p01 - mul_rnd(k0, c01, 28));
    kf_p10 = sat32(kf_p10 - mul_rnd(k1, c00, 28));
    kf_p11 = sat32(kf_p11 - mul_rnd(k1, c01, 28));
    res.angle = kf_angle[31:0];
    res.bias = kf_bias[31:0];
    res.rate = rate[31:0];
    return res;
  endfunction

  function automatic int rand_sym(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ANGLE_NOISE: kf_qa = val;
      CFG_BIAS_NOISE:  kf_qb = val;
      CFG_MEAS_NOISE:  kf_r = val;
      default: ;
    endcase
  endtask

  task automatic set_noise(input logic [CfgW-1:0] qa, input logic [CfgW-1:0] qb,
                           input logic [CfgW-1:0] r);
    write_reg(CFG_ANGLE_NOISE, qa);
    write_reg(CFG_BIAS_NOISE, qb);
    write_reg(CFG_MEAS_NOISE, r);
    noise_sets++;
  endtask

  // one sample transfer; tvalid stays high when the next sample follows at once
  task automatic send_sample(input logic [31:0] meas, input logic [31:0] gyro,
                             input logic [15:0] dt);
    @(negedge clk_i);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dt, gyro, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(kf_update(longint'($signed(meas)), longint'($signed(gyro)),
                                   longint'(dt)));
    samples_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // mostly a plausible tilt trajectory, some fully random samples
  task automatic send_motion_sample();
    logic [15:0] dt;
    longint meas, gyro;
    if ($urandom_range(0, 99) < 15) begin
      send_sample($urandom, $urandom, 16'($urandom_range(0, 65535)));
    end else begin
      dt = ($urandom_range(0, 99) < 3) ? 16'd0 : 16'($urandom_range(40, 1500));
      if ($urandom_range(0, 99) < 5) true_rate = rand_sym(200 * 65536);
      true_angle = true_angle + ((true_rate * longint'(dt)) >>> 16);
      if (true_angle > 180 * 65536 || true_angle < -180 * 65536) begin
        true_angle = 0;
      end
      meas = sat32(true_angle + rand_sym(2 * 65536));
      gyro = sat32(true_rate + true_bias + rand_sym(65536));
      send_sample(meas[31:0], gyro[31:0], dt);
    end
  endtask

  // zero measurement noise with zero covariance leaves nothing to divide by
  task automatic test_zero_innovation_variance();
    write_reg(CFG_MEAS_NOISE, '0);
    send_sample(32'h7fff_ffff, 32'h0001_0000, 16'd0);
    send_sample(32'h8000_0000, 32'hffff_0000, 16'd0);
    send_sample(32'h0000_0000, 32'h0000_0000, 16'd0);
    send_sample(32'h0005_0000, 32'h0002_0000, 16'd655);
    send_sample(32'h0005_0000, 32'h0002_0000, 16'd0);
    wait_drained();
    write_reg(CfgIdxUnused, CfgMax);
    set_noise(AngleNoiseRst, BiasNoiseRst, MeasNoiseRst);
  endtask

  task automatic test_field_extremes();
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'hffff);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 16'd1);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 16'd0);
    send_sample(32'h0000_0000, 32'h0000_0000, 16'hffff);
    send_sample(32'hffff_ffff, 32'h0000_0001, 16'h8000);
    send_sample(32'h0000_0001, 32'hffff_ffff, 16'h0001);
    send_sample(32'h5555_5555, 32'haaaa_aaaa, 16'h5555);
    send_sample(32'haaaa_aaaa, 32'h5555_5555, 16'haaaa);
    send_sample(32'h0000_0000, 32'h0000_0000, 16'd0);
    send_sample(32'h000a_0000, 32'h0001_0000, 16'd262);
    send_sample(32'h000a_0000, 32'h0001_0000, 16'd262);
    wait_drained();
  endtask

  task automatic test_random_stream(input int count, input int s_idle, input int r_idle,
                                    input logic [CfgW-1:0] qa, input logic [CfgW-1:0] qb,
                                    input logic [CfgW-1:0] r);
    set_noise(qa, qb, r);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    true_bias = rand_sym(10 * 65536);
    repeat (count) send_motion_sample();
    wait_drained();
  endtask

  // result side stalls for a long stretch while samples keep coming
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1;
    repeat (8) send_motion_sample();
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = 400;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= int'($urandom_range(0, 99)) >= recv_idle_pct;
    end
  end

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)", $time,
               name, $signed(exp_val), exp_val, $signed(act_val), act_val);
    end
  endtask

  always @(posedge clk_i) begin
    filt_out_t exp_res, act_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_res = m_axis_tdata;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result transfer with no sample outstanding, actual 0x%024h",
                 $time, m_axis_tdata);
      end else begin
        exp_res = expected_q.pop_front();
        compare_field("est_angle", exp_res.angle, act_res.angle);
        compare_field("est_bias", exp_res.bias, act_res.bias);
        compare_field("unbiased_rate", exp_res.rate, act_res.rate);
        results_checked++;
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 0;
    hold_left = 0;
    errors = 0;
    samples_sent = 0;
    results_checked = 0;
    noise_sets = 0;
    zero_gain_steps = 0;
    kf_angle = 0;
    kf_bias = 0;
    kf_p00 = 0;
    kf_p01 = 0;
    kf_p10 = 0;
    kf_p11 = 0;
    kf_qa = AngleNoiseRst;
    kf_qb = BiasNoiseRst;
    kf_r = MeasNoiseRst;
    true_angle = 0;
    true_rate = 0;
    true_bias = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_innovation_variance();
    test_field_extremes();
    test_output_stall();
    test_random_stream(650, 27, 59, 31'($urandom_range(0, 1 << 24)),
                       31'($urandom_range(0, 1 << 24)), 31'($urandom_range(1, 1 << 26)));
    test_random_stream(250, 59, 27, CfgMax, CfgMax, CfgMax);
    test_random_stream(250, 59, 27, '0, '0, 31'd1);
    test_random_stream(700, 0, 0, 31'($urandom), 31'($urandom), 31'($urandom));

    $display("ran %0d filter updates across %0d noise settings, %0d of them with no gain",
             samples_sent, noise_sets, zero_gain_steps);
    $display("checked %0d results, %0d mismatches", results_checked, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
